### rtl/se3pt_pkg.sv
// ----------------------------------------------------------------------------
// se3pt_pkg: shared types and constants of the rigid-body transform unit
// Holds the item structs, opcodes and register indexes.
// ----------------------------------------------------------------------------
package se3pt_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_POINT   = 2'd0,
    OP_COMPOSE = 2'd1,
    OP_INVERT  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_ROT_W = 3'd3,
    REG_ROT_X = 3'd4,
    REG_ROT_Y = 3'd5,
    REG_ROT_Z = 3'd6,
    REG_NONE  = 3'd7
  } cfg_index_t;

  localparam logic signed [31:0] RotWReset = 32'sh4000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_qw;
    logic signed [31:0] in_qx;
    logic signed [31:0] in_qy;
    logic signed [31:0] in_qz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_qw;
    logic signed [31:0] out_qx;
    logic signed [31:0] out_qy;
    logic signed [31:0] out_qz;
    logic               saturated;
  } out_item_t;

endpackage

### rtl/se3_pose_transform_unit.sv
// ----------------------------------------------------------------------------
// se3_pose_transform_unit: fixed-point SE3 point and pose transform
// Transforms points, composes poses with a configured pose and inverts poses.
// ----------------------------------------------------------------------------
// One item is taken each cycle (busy stays low) and its result is on result
// with result_valid high for one cycle. The pipeline holds the input
// register, the two chained quaternion products of the rotation, each split
// into a multiply stage and a sum-and-round stage, and the output register,
// ahead of which the position add and the clip sit. The receiver cannot
// stall the unit, so every result must be taken in the cycle it is shown.
// Configuration writes are always accepted and must only happen while
// no item is in flight.
module se3_pose_transform_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  se3pt_pkg::in_item_t               item,
  output logic                              result_valid,
  output se3pt_pkg::out_item_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [se3pt_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  // configuration registers
  logic signed [31:0] pos [3];
  logic signed [31:0] rot [4];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      rot[0] <= se3pt_pkg::RotWReset;
      rot[1] <= '0; rot[2] <= '0; rot[3] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        se3pt_pkg::REG_POS_X: pos[0] <= cfg_data;
        se3pt_pkg::REG_POS_Y: pos[1] <= cfg_data;
        se3pt_pkg::REG_POS_Z: pos[2] <= cfg_data;
        se3pt_pkg::REG_ROT_W: rot[0] <= cfg_data;
        se3pt_pkg::REG_ROT_X: rot[1] <= cfg_data;
        se3pt_pkg::REG_ROT_Y: rot[2] <= cfg_data;
        se3pt_pkg::REG_ROT_Z: rot[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits along the pipe
  logic [5:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[4:0], start};
  end
  assign result_valid = vld[5];

  // stage 1: register input, choose rotation quaternion (33 bits for -2^31)
  logic [1:0]         op1;
  logic signed [32:0] rq1 [4];
  logic signed [31:0] p1  [3];
  logic signed [32:0] q1  [4];
  logic signed [31:0] cp1 [3];
  always_ff @(posedge clk) begin
    op1 <= item.opcode;
    p1[0] <= item.in_x; p1[1] <= item.in_y; p1[2] <= item.in_z;
    q1[0] <= 33'(item.in_qw); q1[1] <= 33'(item.in_qx);
    q1[2] <= 33'(item.in_qy); q1[3] <= 33'(item.in_qz);
    for (int i = 0; i < 3; i++) cp1[i] <= pos[i];
    if (item.opcode == se3pt_pkg::OP_INVERT) begin
      rq1[0] <= 33'(item.in_qw);
      rq1[1] <= -33'(item.in_qx);
      rq1[2] <= -33'(item.in_qy);
      rq1[3] <= -33'(item.in_qz);
    end else begin
      for (int i = 0; i < 4; i++) rq1[i] <= 33'(rot[i]);
    end
  end

  // stage 2: products of t = (0,p)*conj(rq), and of rq*q for composition
  // t.w = p.rq ; t.x = w px - (py rz - pz ry) ... as (0,p)*conj(r)
  logic [1:0]         op2;
  logic signed [64:0] tm2 [4][3];
  logic signed [64:0] cm2 [4][4];
  logic signed [32:0] rq2 [4];
  logic signed [31:0] cp2 [3];
  always_ff @(posedge clk) begin
    op2 <= op1;
    rq2 <= rq1;
    cp2 <= cp1;
    // (0,p)*(w,-x,-y,-z)
    tm2[0][0] <= 65'(p1[0]) * 65'(rq1[1]);
    tm2[0][1] <= 65'(p1[1]) * 65'(rq1[2]);
    tm2[0][2] <= 65'(p1[2]) * 65'(rq1[3]);
    tm2[1][0] <= 65'(p1[0]) * 65'(rq1[0]);
    tm2[1][1] <= 65'(p1[1]) * 65'(rq1[3]);
    tm2[1][2] <= 65'(p1[2]) * 65'(rq1[2]);
    tm2[2][0] <= 65'(p1[1]) * 65'(rq1[0]);
    tm2[2][1] <= 65'(p1[2]) * 65'(rq1[1]);
    tm2[2][2] <= 65'(p1[0]) * 65'(rq1[3]);
    tm2[3][0] <= 65'(p1[2]) * 65'(rq1[0]);
    tm2[3][1] <= 65'(p1[0]) * 65'(rq1[2]);
    tm2[3][2] <= 65'(p1[1]) * 65'(rq1[1]);
    // rq*q
    for (int i = 0; i < 4; i++) begin
      cm2[0][i] <= 65'(rq1[i]) * 65'(q1[i]);
    end
    cm2[1][0] <= 65'(rq1[0]) * 65'(q1[1]);
    cm2[1][1] <= 65'(rq1[1]) * 65'(q1[0]);
    cm2[1][2] <= 65'(rq1[2]) * 65'(q1[3]);
    cm2[1][3] <= 65'(rq1[3]) * 65'(q1[2]);
    cm2[2][0] <= 65'(rq1[0]) * 65'(q1[2]);
    cm2[2][1] <= 65'(rq1[1]) * 65'(q1[3]);
    cm2[2][2] <= 65'(rq1[2]) * 65'(q1[0]);
    cm2[2][3] <= 65'(rq1[3]) * 65'(q1[1]);
    cm2[3][0] <= 65'(rq1[0]) * 65'(q1[3]);
    cm2[3][1] <= 65'(rq1[1]) * 65'(q1[2]);
    cm2[3][2] <= 65'(rq1[2]) * 65'(q1[1]);
    cm2[3][3] <= 65'(rq1[3]) * 65'(q1[0]);
  end

  // stage 3: sum and round t to 14 fraction bits more than p, and the output rotation
  localparam logic signed [67:0] HalfT = 68'sd1 <<< 15;
  localparam logic signed [67:0] HalfQ = 68'sd1 <<< 29;
  logic [1:0]         op3;
  logic signed [51:0] t3  [4];
  logic signed [37:0] c3  [4];
  logic signed [32:0] rq3 [4];
  logic signed [31:0] cp3 [3];
  logic signed [67:0] ts  [4];
  logic signed [67:0] cs  [4];
  always_comb begin
    // conj(r) negates vector parts
    // t.w = 0*w - p.(-v) = p.v ; t.x = px*w + py*(-vz) - pz*(-vy)
    ts[0] = 68'(tm2[0][0]) + 68'(tm2[0][1]) + 68'(tm2[0][2]);
    ts[1] = 68'(tm2[1][0]) - 68'(tm2[1][1]) + 68'(tm2[1][2]);
    ts[2] = 68'(tm2[2][0]) - 68'(tm2[2][1]) + 68'(tm2[2][2]);
    ts[3] = 68'(tm2[3][0]) - 68'(tm2[3][1]) + 68'(tm2[3][2]);
    cs[0] = 68'(cm2[0][0]) - 68'(cm2[0][1]) - 68'(cm2[0][2]) - 68'(cm2[0][3]);
    cs[1] = 68'(cm2[1][0]) + 68'(cm2[1][1]) + 68'(cm2[1][2]) - 68'(cm2[1][3]);
    cs[2] = 68'(cm2[2][0]) - 68'(cm2[2][1]) + 68'(cm2[2][2]) + 68'(cm2[2][3]);
    cs[3] = 68'(cm2[3][0]) + 68'(cm2[3][1]) - 68'(cm2[3][2]) + 68'(cm2[3][3]);
  end
  always_ff @(posedge clk) begin
    op3 <= op2;
    rq3 <= rq2;
    cp3 <= cp2;
    for (int i = 0; i < 4; i++) begin
      t3[i] <= 52'((ts[i] + HalfT) >>> 16);
      // invert: the output rotation is the conjugate itself
      if (op2 == se3pt_pkg::OP_INVERT) c3[i] <= 38'(rq2[i]);
      else                             c3[i] <= 38'((cs[i] + HalfQ) >>> 30);
    end
  end

  // stage 4: products of r = rq*t (vector part only), t split at bit 24
  // row j uses t part k ^ (j + 1) against rq part k
  logic [1:0]         op4;
  logic signed [60:0] rh4 [3][4];
  logic signed [57:0] rl4 [3][4];
  logic signed [37:0] c4  [4];
  logic signed [31:0] cp4 [3];
  logic signed [27:0] th  [4];
  logic signed [24:0] tl  [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      th[i] = t3[i][51:24];
      tl[i] = {1'b0, t3[i][23:0]};
    end
  end
  always_ff @(posedge clk) begin
    op4 <= op3;
    c4  <= c3;
    cp4 <= cp3;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 4; k++) begin
        rh4[j][k] <= 61'(rq3[k]) * 61'(th[k ^ (j + 1)]);
        rl4[j][k] <= 58'(rq3[k]) * 58'(tl[k ^ (j + 1)]);
      end
    end
  end

  // stage 5: sum partial products, rejoin and round by 44 bits
  localparam logic signed [87:0] HalfR = 88'sd1 <<< 43;
  logic [1:0]         op5;
  logic signed [43:0] r5  [3];
  logic signed [37:0] c5  [4];
  logic signed [31:0] cp5 [3];
  logic signed [63:0] hs  [3];
  logic signed [60:0] ls  [3];
  logic signed [87:0] rs  [3];
  logic signed [43:0] rr  [3];
  always_comb begin
    hs[0] = 64'(rh4[0][0]) + 64'(rh4[0][1]) + 64'(rh4[0][2]) - 64'(rh4[0][3]);
    hs[1] = 64'(rh4[1][0]) - 64'(rh4[1][1]) + 64'(rh4[1][2]) + 64'(rh4[1][3]);
    hs[2] = 64'(rh4[2][0]) + 64'(rh4[2][1]) - 64'(rh4[2][2]) + 64'(rh4[2][3]);
    ls[0] = 61'(rl4[0][0]) + 61'(rl4[0][1]) + 61'(rl4[0][2]) - 61'(rl4[0][3]);
    ls[1] = 61'(rl4[1][0]) - 61'(rl4[1][1]) + 61'(rl4[1][2]) + 61'(rl4[1][3]);
    ls[2] = 61'(rl4[2][0]) + 61'(rl4[2][1]) - 61'(rl4[2][2]) + 61'(rl4[2][3]);
    for (int i = 0; i < 3; i++) begin
      rs[i] = (88'(hs[i]) <<< 24) + 88'(ls[i]);
      rr[i] = 44'((rs[i] + HalfR) >>> 44);
    end
  end
  always_ff @(posedge clk) begin
    op5 <= op4;
    c5  <= c4;
    cp5 <= cp4;
    r5  <= rr;
  end

  // stage 6: add or negate position, select by opcode and clip
  logic signed [44:0] ps [3];
  logic signed [44:0] sv [7];
  logic [6:0]         clip;
  logic signed [31:0] cv [7];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op5 == se3pt_pkg::OP_INVERT) ps[i] = -45'(r5[i]);
      else                             ps[i] = 45'(r5[i]) + 45'(cp5[i]);
    end
    for (int i = 0; i < 7; i++) sv[i] = '0;
    unique case (op5)
      se3pt_pkg::OP_POINT: begin
        for (int i = 0; i < 3; i++) sv[i] = ps[i];
      end
      se3pt_pkg::OP_COMPOSE, se3pt_pkg::OP_INVERT: begin
        for (int i = 0; i < 3; i++) sv[i] = ps[i];
        for (int i = 0; i < 4; i++) sv[3+i] = 45'(c5[i]);
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) begin
      clip[i] = 1'b0;
      cv[i]   = sv[i][31:0];
      if (sv[i] > 45'sh0_7FFF_FFFF) begin
        cv[i] = 32'sh7FFF_FFFF; clip[i] = 1'b1;
      end else if (sv[i] < -45'sh0_8000_0000) begin
        cv[i] = 32'sh8000_0000; clip[i] = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    result.out_x  <= cv[0];
    result.out_y  <= cv[1];
    result.out_z  <= cv[2];
    result.out_qw <= cv[3];
    result.out_qx <= cv[4];
    result.out_qy <= cv[5];
    result.out_qz <= cv[6];
    result.saturated <= |clip;
  end

endmodule
